[design/fltw_pkg.sv]
// Package: constants, payload types and sequencer states of the page-table walker.
`default_nettype none
package fltw_pkg;

  localparam int unsigned TablesDefault = 16;
  localparam int unsigned EntryWidth    = 64;
  localparam int unsigned IdxWidth      = 9;
  localparam int unsigned FrameWidth    = 40;
  localparam int unsigned VaWidth       = 48;

  localparam logic [1:0] CmdMap       = 2'd0;
  localparam logic [1:0] CmdUnmap     = 2'd1;
  localparam logic [1:0] CmdTranslate = 2'd2;

  localparam logic [1:0] StatusOk     = 2'd0;
  localparam logic [1:0] StatusFault  = 2'd1;
  localparam logic [1:0] StatusNoRoom = 2'd2;

  localparam int unsigned BitPresent = 0;
  localparam int unsigned BitRw      = 1;
  localparam int unsigned BitUser    = 2;

  typedef struct packed {
    logic [1:0]            cmd;
    logic [VaWidth-1:0]    virt_addr;
    logic [FrameWidth-1:0] phys_frame;
    logic                  user_access;
    logic                  writable;
  } in_item_t;

  typedef struct packed {
    logic [1:0]            status;
    logic [FrameWidth-1:0] result_frame;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHK_RD,
    ST_CHK_WAIT,
    ST_CHK_EVAL,
    ST_UPD_RD,
    ST_UPD_WAIT,
    ST_UPD_EVAL,
    ST_OUT
  } state_t;

  // Frame field of an entry
  function automatic logic [FrameWidth-1:0] frame_of(input logic [EntryWidth-1:0] e);
    return e[12 +: FrameWidth];
  endfunction

  // Nine-bit index of a level, root is level 0
  function automatic logic [IdxWidth-1:0] idx_of(input logic [VaWidth-1:0] va,
                                                 input logic [1:0] lvl);
    logic [IdxWidth-1:0] r;
    case (lvl)
      2'd0:    r = va[47:39];
      2'd1:    r = va[38:30];
      2'd2:    r = va[29:21];
      default: r = va[20:12];
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

[design/fltw_ram.sv]
// Generic single-port RAM with registered read.
`default_nettype none
module fltw_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 8192
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read returns the old contents when a write hits the same address
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

[design/four_level_page_table_walker.sv]
// Top level: four-level page-table walker over an internal table store.
//
// Input channel (in_valid/in_stall/in_item) takes one command transaction:
// map, unmap or translate of a 48-bit virtual address. Output channel
// (out_valid/out_stall/out_item) returns exactly one status transaction per
// command. One command is processed at a time; in_stall is high from the
// accepted command until its result has been taken.
// Every entry access goes through the single port of the table store, with
// a registered read; each level takes a read, a wait and an evaluate state.
// Unmap and translate walk up to four levels this way and then register the
// result. Map checks up to 3 levels then updates 4 levels read-modify-write.
// The result register holds its value while out_stall is high; the next
// command can be taken in the cycle after the result transaction.
// After reset the store is cleared one entry per cycle, during which no
// command is accepted; cfg writes are taken at any time.
// The cfg register sets the frame number of table zero; the user must write
// it with cfg_we/cfg_wdata only while the block is idle; the block itself
// does not enforce this.
`default_nettype none
module four_level_page_table_walker #(
  parameter int unsigned TABLES = fltw_pkg::TablesDefault
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire fltw_pkg::in_item_t            in_item,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output fltw_pkg::out_item_t                out_item,
  input  wire logic                          cfg_we,
  input  wire logic [fltw_pkg::FrameWidth-1:0] cfg_wdata
);
  import fltw_pkg::*;

  localparam int unsigned Depth = TABLES * 512;
  localparam int unsigned AW    = $clog2(Depth);
  localparam int unsigned TW    = $clog2(TABLES + 1);

  state_t state_r, state_nxt;
  in_item_t item_r, item_nxt;
  logic [AW-1:0] clr_r, clr_nxt;
  logic [1:0] lvl_r, lvl_nxt;
  logic [TW-1:0] tbl_r, tbl_nxt;          // current table of the walk
  logic [TW-1:0] free_r, free_nxt;        // next free table
  logic [FrameWidth-1:0] base_r;
  out_item_t res_r, res_nxt;
  logic out_valid_r, out_valid_nxt;

  logic ram_we;
  logic [AW-1:0] ram_addr;
  logic [EntryWidth-1:0] ram_wdata, ram_rdata;

  fltw_ram #(.WIDTH(EntryWidth), .DEPTH(Depth)) u_store (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
  );

  // Slot address of the current level
  logic [AW-1:0] slot;
  assign slot = AW'((32'(tbl_r) << 9) | 32'(idx_of(item_r.virt_addr, lvl_r)));

  // Decode of a present entry's target table
  logic [FrameWidth-1:0] tgt_off;
  logic tgt_ok;
  assign tgt_off = frame_of(ram_rdata) - base_r;
  assign tgt_ok  = (tgt_off < FrameWidth'(free_r)) && (tgt_off < FrameWidth'(TABLES));

  logic [FrameWidth-1:0] alloc_frame;
  assign alloc_frame = base_r + FrameWidth'(free_r);

  // Entry rewritten by map at the current level
  logic [EntryWidth-1:0] upd_e;
  always_comb begin
    upd_e = ram_rdata;
    if (lvl_r == 2'd3) begin
      upd_e[12 +: FrameWidth] = item_r.phys_frame;
      upd_e[BitPresent] = 1'b1;
    end else if (!ram_rdata[BitPresent]) begin
      upd_e[12 +: FrameWidth] = alloc_frame;
      upd_e[BitPresent] = 1'b1;
    end
    upd_e[BitRw]   = item_r.writable;
    upd_e[BitUser] = item_r.user_access;
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = res_r;

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    item_nxt = item_r;
    clr_nxt = clr_r;
    lvl_nxt = lvl_r;
    tbl_nxt = tbl_r;
    free_nxt = free_r;
    res_nxt = res_r;
    out_valid_nxt = out_valid_r;
    ram_we = 1'b0;
    ram_addr = slot;
    ram_wdata = upd_e;
    case (state_r)
      ST_CLEAR: begin
        ram_we = 1'b1;
        ram_addr = clr_r;
        ram_wdata = '0;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == AW'(Depth - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          item_nxt = in_item;
          lvl_nxt = 2'd0;
          tbl_nxt = '0;
          state_nxt = ST_CHK_RD;
        end
      end
      ST_CHK_RD: begin
        if (item_r.cmd == CmdMap || item_r.cmd == CmdUnmap ||
            item_r.cmd == CmdTranslate) begin
          state_nxt = ST_CHK_WAIT;
        end else begin
          res_nxt = '{status: StatusOk, result_frame: '0};
          state_nxt = ST_OUT;
        end
      end
      ST_CHK_WAIT: state_nxt = ST_CHK_EVAL;
      ST_CHK_EVAL: begin
        if (lvl_r == 2'd3) begin
          // Leaf reached by unmap or translate
          res_nxt = '{status: StatusOk, result_frame: '0};
          if (item_r.cmd == CmdTranslate) begin
            res_nxt.result_frame = frame_of(ram_rdata);
          end else begin
            ram_we = 1'b1;
            ram_wdata = ram_rdata & ~(EntryWidth'(1) << BitPresent);
          end
          state_nxt = ST_OUT;
        end else if (!ram_rdata[BitPresent] || !tgt_ok) begin
          if (item_r.cmd == CmdMap && ram_rdata[BitPresent] == 1'b0) begin
            // Walk stops here; the rest needs fresh tables
            if (32'(free_r) + 32'(2'd3 - lvl_r) > 32'(TABLES)) begin
              res_nxt = '{status: StatusNoRoom, result_frame: '0};
              state_nxt = ST_OUT;
            end else begin
              lvl_nxt = 2'd0;
              tbl_nxt = '0;
              state_nxt = ST_UPD_RD;
            end
          end else begin
            res_nxt = '{status: StatusFault, result_frame: '0};
            state_nxt = ST_OUT;
          end
        end else begin
          tbl_nxt = TW'(tgt_off);
          lvl_nxt = lvl_r + 1'b1;
          if (item_r.cmd == CmdMap && lvl_r == 2'd2) begin
            lvl_nxt = 2'd0;
            tbl_nxt = '0;
            state_nxt = ST_UPD_RD;
          end else begin
            state_nxt = ST_CHK_RD;
          end
        end
      end
      ST_UPD_RD: state_nxt = ST_UPD_WAIT;
      ST_UPD_WAIT: state_nxt = ST_UPD_EVAL;
      ST_UPD_EVAL: begin
        ram_we = 1'b1;
        if (lvl_r == 2'd3) begin
          res_nxt = '{status: StatusOk, result_frame: '0};
          state_nxt = ST_OUT;
        end else begin
          if (!ram_rdata[BitPresent]) begin
            tbl_nxt = free_r;
            free_nxt = free_r + 1'b1;
          end else begin
            tbl_nxt = TW'(tgt_off);
          end
          lvl_nxt = lvl_r + 1'b1;
          state_nxt = ST_UPD_RD;
        end
      end
      ST_OUT: begin
        if (!out_valid_r) begin
          out_valid_nxt = 1'b1;
        end else if (!out_stall) begin
          out_valid_nxt = 1'b0;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r <= '0;
      free_r <= TW'(1);
      out_valid_r <= 1'b0;
      base_r <= '0;
      lvl_r <= '0;
      tbl_r <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r <= clr_nxt;
      free_r <= free_nxt;
      out_valid_r <= out_valid_nxt;
      lvl_r <= lvl_nxt;
      tbl_r <= tbl_nxt;
      if (cfg_we) base_r <= cfg_wdata;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    res_r <= res_nxt;
  end

endmodule
`default_nettype wire
